// ===== hw/rtl/lprd_pkg.sv =====
`default_nettype none

package lprd_pkg;

   localparam int BYTE_W   = 8;
   localparam int LEN_W    = 32;
   localparam int KIND_W   = 3;
   localparam int CSR_IDX_W = 1;
   localparam int LEN_BYTES = 4;

   localparam logic [1:0] LEN_IDX_LAST = 2'(LEN_BYTES - 1);

   localparam logic [KIND_W-1:0] KIND_METHOD = 3'd0;
   localparam logic [KIND_W-1:0] KIND_PLEN   = 3'd1;
   localparam logic [KIND_W-1:0] KIND_PATH   = 3'd2;
   localparam logic [KIND_W-1:0] KIND_BLEN   = 3'd3;
   localparam logic [KIND_W-1:0] KIND_BODY   = 3'd4;

   localparam logic [CSR_IDX_W-1:0] CSR_MAX_PATH = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_BODY = 1'd1;

   localparam logic [LEN_W-1:0] LEN_LIMIT_RESET = '1;

   typedef enum logic [4:0] {
      PH_METHOD = 5'b00001,
      PH_PLEN   = 5'b00010,
      PH_PATH   = 5'b00100,
      PH_BLEN   = 5'b01000,
      PH_BODY   = 5'b10000
   } phase_type;

   typedef struct packed {
      phase_type         phase;
      logic [1:0]        len_idx;
      logic [LEN_W-1:0]  len_acc;
      logic [LEN_W-1:0]  bytes_rem;
   } parse_state_type;

   typedef struct packed {
      logic [KIND_W-1:0] field_kind;
      logic [BYTE_W-1:0] byte_value;
      logic              field_last;
      logic              frame_end;
      logic [LEN_W-1:0]  declared_length;
      logic              too_long;
   } result_type;

   typedef struct packed {
      logic [LEN_W-1:0] max_path_length;
      logic [LEN_W-1:0] max_body_length;
   } limits_type;

endpackage

`default_nettype wire

// ===== hw/rtl/lprd_req_if.sv =====
`default_nettype none

interface lprd_req_if;
   import lprd_pkg::*;

   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] data_byte;

   modport source (output valid, output data_byte, input ready);
   modport sink   (input valid, input data_byte, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/lprd_rsp_if.sv =====
`default_nettype none

interface lprd_rsp_if;
   import lprd_pkg::*;

   logic              valid;
   logic              ready;
   logic [KIND_W-1:0] field_kind;
   logic [BYTE_W-1:0] byte_value;
   logic              field_last;
   logic              frame_end;
   logic [LEN_W-1:0]  declared_length;
   logic              too_long;

   modport source (output valid, output field_kind, output byte_value, output field_last,
                   output frame_end, output declared_length, output too_long, input ready);
   modport sink   (input valid, input field_kind, input byte_value, input field_last,
                   input frame_end, input declared_length, input too_long, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/lprd_parse.sv =====
`default_nettype none

module lprd_parse (
   input  lprd_pkg::parse_state_type state,
   input  logic [lprd_pkg::BYTE_W-1:0] data_byte,
   input  lprd_pkg::limits_type      limits,
   output lprd_pkg::parse_state_type state_next,
   output lprd_pkg::result_type      result
);
   import lprd_pkg::*;

   logic [LEN_W-1:0] acc_shift;
   logic [LEN_W-1:0] rem_dec;
   logic [LEN_W-1:0] limit;
   logic             is_path;

   assign acc_shift = {state.len_acc[LEN_W-BYTE_W-1:0], data_byte};
   assign rem_dec   = (state.bytes_rem != '0) ? state.bytes_rem - LEN_W'(1) : state.bytes_rem;
   assign is_path   = (state.phase == PH_PLEN) || (state.phase == PH_PATH);
   assign limit     = is_path ? limits.max_path_length : limits.max_body_length;

   always_comb begin
      state_next             = state;
      result.field_kind      = KIND_METHOD;
      result.byte_value      = data_byte;
      result.field_last      = 1'b0;
      result.frame_end       = 1'b0;
      result.declared_length = '0;
      result.too_long        = 1'b0;

      case (state.phase)
         PH_PLEN, PH_BLEN: begin
            result.field_kind = is_path ? KIND_PLEN : KIND_BLEN;
            if (state.len_idx == LEN_IDX_LAST) begin
               result.field_last      = 1'b1;
               result.declared_length = acc_shift;
               result.too_long        = acc_shift > limit;
               state_next.bytes_rem   = acc_shift;
               state_next.len_idx     = '0;
               state_next.len_acc     = '0;
               if (acc_shift != '0) begin
                  state_next.phase = is_path ? PH_PATH : PH_BODY;
               end else if (is_path) begin
                  state_next.phase = PH_BLEN;
               end else begin
                  result.frame_end = 1'b1;
                  state_next.phase = PH_METHOD;
               end
            end else begin
               state_next.len_idx = state.len_idx + 2'd1;
               state_next.len_acc = acc_shift;
            end
         end
         PH_PATH, PH_BODY: begin
            result.field_kind    = is_path ? KIND_PATH : KIND_BODY;
            state_next.bytes_rem = rem_dec;
            if (rem_dec == '0) begin
               result.field_last  = 1'b1;
               state_next.len_idx = '0;
               state_next.len_acc = '0;
               if (is_path) begin
                  state_next.phase = PH_BLEN;
               end else begin
                  result.frame_end = 1'b1;
                  state_next.phase = PH_METHOD;
               end
            end
         end
         default: begin
            result.field_last    = 1'b1;
            state_next.phase     = PH_PLEN;
            state_next.len_idx   = '0;
            state_next.len_acc   = '0;
            state_next.bytes_rem = '0;
         end
      endcase
   end

endmodule

`default_nettype wire

// ===== hw/rtl/length_prefixed_request_deframer.sv =====
// Request frame deframer: one received byte per req_channel transaction,
// one tagged result per rsp_channel transaction.
// Frame: method byte, 4-byte big-endian path length, path bytes,
// 4-byte big-endian body length, body bytes; then the next frame starts.
// Each result carries field_kind, the byte, field_last, frame_end, and on the
// last length byte the assembled declared_length and the too_long flag.
// Latency: the result is valid in the cycle after its byte is accepted.
// Throughput: one byte per cycle unless stalled; the parse state update and
// the result register are one short step (32-bit compare, 32-bit decrement).
// Stall: the result register holds while rsp_channel.ready is low, and
// req_channel.ready drops until the pending result is taken.
// Config: csr_write_enable writes csr_write_data to register csr_index
// (0 max_path_length, 1 max_body_length); write only while idle.
// Reset (synchronous, active high): parser returns to the method byte,
// no result pending, both limits set to all ones.
`default_nettype none

module length_prefixed_request_deframer (
   input  logic                              clock,
   input  logic                              reset,
   lprd_req_if.sink                          req_channel,
   lprd_rsp_if.source                        rsp_channel,
   input  logic                              csr_write_enable,
   input  logic [lprd_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [lprd_pkg::LEN_W-1:0]        csr_write_data
);
   import lprd_pkg::*;

   parse_state_type state_ff, state_in;
   result_type      result_ff, result_in;
   limits_type      limits_ff, limits_in;
   logic            rsp_valid_ff, rsp_valid_in;
   logic            req_take;

   assign req_channel.ready = !rsp_valid_ff || rsp_channel.ready;
   assign req_take          = req_channel.valid && req_channel.ready;

   lprd_parse u_parse (
      .state      (state_ff),
      .data_byte  (req_channel.data_byte),
      .limits     (limits_ff),
      .state_next (state_in),
      .result     (result_in)
   );

   always_comb begin
      limits_in = limits_ff;
      if (csr_write_enable) begin
         case (csr_index)
            CSR_MAX_PATH: limits_in.max_path_length = csr_write_data;
            CSR_MAX_BODY: limits_in.max_body_length = csr_write_data;
            default:      limits_in = limits_ff;
         endcase
      end
   end

   assign rsp_valid_in = req_take || (rsp_valid_ff && !rsp_channel.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff.phase                  <= PH_METHOD;
         state_ff.len_idx                <= '0;
         state_ff.len_acc                <= '0;
         state_ff.bytes_rem              <= '0;
         limits_ff.max_path_length       <= LEN_LIMIT_RESET;
         limits_ff.max_body_length       <= LEN_LIMIT_RESET;
         rsp_valid_ff                    <= 1'b0;
      end else begin
         if (req_take) begin
            state_ff <= state_in;
         end
         limits_ff    <= limits_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         result_ff <= result_in;
      end
   end

   assign rsp_channel.valid           = rsp_valid_ff;
   assign rsp_channel.field_kind      = result_ff.field_kind;
   assign rsp_channel.byte_value      = result_ff.byte_value;
   assign rsp_channel.field_last      = result_ff.field_last;
   assign rsp_channel.frame_end       = result_ff.frame_end;
   assign rsp_channel.declared_length = result_ff.declared_length;
   assign rsp_channel.too_long        = result_ff.too_long;

`ifndef SYNTHESIS
   a_frame_end_last: assert property (@(posedge clock)
      rsp_valid_ff && result_ff.frame_end |-> result_ff.field_last)
      else $error("frame_end without field_last");

   a_too_long_on_len: assert property (@(posedge clock)
      rsp_valid_ff && result_ff.too_long |->
         result_ff.field_last &&
         (result_ff.field_kind == KIND_PLEN || result_ff.field_kind == KIND_BLEN))
      else $error("too_long outside a last length byte");

   a_dlen_on_len: assert property (@(posedge clock)
      rsp_valid_ff && (result_ff.declared_length != '0) |->
         result_ff.field_last &&
         (result_ff.field_kind == KIND_PLEN || result_ff.field_kind == KIND_BLEN))
      else $error("declared_length outside a last length byte");

   a_reset_phase: assert property (@(posedge clock)
      reset |=> (state_ff.phase == PH_METHOD) && !rsp_valid_ff)
      else $error("parser not at method byte after reset");

   a_stall_blocks: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_channel.ready |-> !req_channel.ready)
      else $error("input accepted while result stalled");
`endif

endmodule

`default_nettype wire
